/* design/phft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak hold / fall tracker package
// Shared types, Q16 constants and saturation helpers for the peak hold block.
// ----------------------------------------------------------------------------
package phft_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int BAND_COUNT_DEF = 256;
  localparam int BAND_W         = 8;
  localparam int LEVEL_W        = 17;
  localparam int PEAK_W         = 19;
  localparam int HOLD_W         = 27;
  localparam int FALL_W         = 24;
  localparam int HFRAMES_W      = 26;
  localparam int RECIP_W        = 17;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 26;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 40;

  localparam int Q_ONE   = 1 << FRAC_BITS;
  localparam int Q_HALF  = 1 << (FRAC_BITS - 1);
  localparam int Q_TENTH = (Q_ONE + 5) / 10;

  localparam int PEAK_MIN = -(1 << (PEAK_W - 1));
  localparam int PEAK_MAX = (1 << (PEAK_W - 1)) - 1;
  localparam int HOLD_MIN = -(1 << (HOLD_W - 1));
  localparam int HOLD_MAX = (1 << (HOLD_W - 1)) - 1;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_CLASSIC   = 3'd1,
    MODE_GRAVITY   = 3'd2,
    MODE_FADE      = 3'd3,
    MODE_RISE      = 3'd4,
    MODE_RISE_FADE = 3'd5
  } peak_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PEAK_MODE     = 2'd0,
    REG_HOLD_FRAMES   = 2'd1,
    REG_HOLD_RECIP    = 2'd2,
    REG_METER_VARIANT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]           peak_mode;
    logic [HFRAMES_W-1:0] hold_frames;
    logic [RECIP_W-1:0]   hold_reciprocal;
    logic                 meter_variant;
  } cfg_t;

  typedef struct packed {
    logic signed [PEAK_W-1:0] peak;
    logic signed [HOLD_W-1:0] hold;
    logic [FALL_W-1:0]        fall;
    logic signed [PEAK_W-1:0] opac;
  } band_state_t;

  function automatic logic signed [PEAK_W-1:0] sat_peak(input logic signed [31:0] x);
    logic signed [PEAK_W-1:0] r;
    if (x < 32'sd0 + PEAK_MIN) begin
      r = PEAK_W'(PEAK_MIN);
    end else if (x > 32'sd0 + PEAK_MAX) begin
      r = PEAK_W'(PEAK_MAX);
    end else begin
      r = x[PEAK_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [HOLD_W-1:0] sat_hold(input logic signed [31:0] x);
    logic signed [HOLD_W-1:0] r;
    if (x < 32'sd0 + HOLD_MIN) begin
      r = HOLD_W'(HOLD_MIN);
    end else if (x > 32'sd0 + HOLD_MAX) begin
      r = HOLD_W'(HOLD_MAX);
    end else begin
      r = x[HOLD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/phft_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module phft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/phft_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Band state update
// Capture, hold countdown, mode dependent fall and clamp for one band entry.
// ----------------------------------------------------------------------------
module phft_update import phft_pkg::*; (
  input  wire cfg_t               cfg,
  input  wire band_state_t        st,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [LEVEL_W-1:0] fall_step,
  output band_state_t             st_next
);

  logic                     rise;
  logic                     capture;
  logic signed [31:0]       level_s;
  logic signed [31:0]       peak_s;
  logic signed [31:0]       opac_s;
  logic signed [31:0]       hold_s;
  logic [PEAK_W-1:0]        rise_diff;
  logic [PEAK_W+HFRAMES_W-1:0] rise_prod;
  logic [RECIP_W-1:0]       part;
  logic [2*RECIP_W-1:0]     creep_prod;
  logic signed [HOLD_W-1:0] hold_dec;
  logic signed [HOLD_W-1:0] hf_s;
  logic [FALL_W:0]          tenth_sum;
  logic [FALL_W:0]          acc_sum;
  logic [FALL_W-1:0]        fall_classic;
  logic [FALL_W-1:0]        fall_acc;
  logic [FALL_W-1:0]        fall_rise;
  logic [FALL_W-1:0]        fall_sel;
  logic signed [PEAK_W-1:0] peak_dropped;
  logic signed [PEAK_W-1:0] opac_dropped;
  logic signed [PEAK_W-1:0] peak_w;

  always_comb begin
    rise      = (cfg.peak_mode == MODE_RISE) || (cfg.peak_mode == MODE_RISE_FADE);
    level_s   = $signed({15'b0, level});
    peak_s    = 32'(st.peak);
    opac_s    = 32'(st.opac);
    hold_s    = 32'(st.hold);
    hf_s      = $signed({1'b0, cfg.hold_frames});
    capture   = level_s >= peak_s;

    // rise in level scaled by the hold length
    rise_diff = PEAK_W'(level_s - peak_s);
    rise_prod = rise_diff * cfg.hold_frames;

    // upward creep during the hold, by the spent fraction
    part       = (st.hold < HOLD_W'(Q_ONE)) ? st.hold[RECIP_W-1:0] : RECIP_W'(Q_ONE);
    creep_prod = part * cfg.hold_reciprocal;
    hold_dec   = st.hold - HOLD_W'(Q_ONE);

    tenth_sum    = (FALL_W+1)'(st.fall) + (FALL_W+1)'(Q_TENTH);
    if (cfg.meter_variant) begin
      fall_classic = FALL_W'(fall_step);
    end else if (tenth_sum > (FALL_W+1)'(fall_step)) begin
      fall_classic = FALL_W'(fall_step);
    end else begin
      fall_classic = tenth_sum[FALL_W-1:0];
    end
    acc_sum   = (FALL_W+1)'(st.fall) + (FALL_W+1)'(fall_step);
    fall_acc  = acc_sum[FALL_W] ? {FALL_W{1'b1}} : acc_sum[FALL_W-1:0];
    fall_rise = (st.peak < PEAK_W'(Q_HALF)) ? FALL_W'({fall_step, 1'b0})
                                            : FALL_W'(fall_step);

    case (cfg.peak_mode)
      MODE_CLASSIC:              fall_sel = fall_classic;
      MODE_GRAVITY, MODE_FADE:   fall_sel = fall_acc;
      MODE_RISE, MODE_RISE_FADE: fall_sel = fall_rise;
      default:                   fall_sel = st.fall;
    endcase
    peak_dropped = sat_peak(peak_s - $signed({8'b0, fall_sel}));
    opac_dropped = sat_peak(opac_s - $signed({8'b0, fall_sel}));

    st_next = st;
    peak_w  = st.peak;
    if (capture) begin
      if (rise) begin
        st_next.hold = sat_hold(hold_s +
                                $signed({3'b0, rise_prod[PEAK_W+HFRAMES_W-1:FRAC_BITS]}));
      end else begin
        st_next.hold = hf_s;
      end
      st_next.peak = PEAK_W'(level_s);
      st_next.fall = '0;
      st_next.opac = PEAK_W'(Q_ONE);
    end else begin
      if (st.hold > 0) begin
        if (rise) begin
          peak_w = sat_peak(peak_s +
                            $signed({14'b0, creep_prod[2*RECIP_W-1:FRAC_BITS]}));
        end
        st_next.hold = (rise && (hold_dec > hf_s)) ? hf_s : hold_dec;
      end else begin
        case (cfg.peak_mode)
          MODE_CLASSIC, MODE_GRAVITY, MODE_RISE: begin
            st_next.fall = fall_sel;
            peak_w       = peak_dropped;
          end
          MODE_FADE: begin
            st_next.fall = fall_sel;
            st_next.opac = opac_dropped;
            if (opac_dropped <= 0) peak_w = PEAK_W'(level_s);
          end
          MODE_RISE_FADE: begin
            st_next.fall = fall_sel;
            st_next.opac = opac_dropped;
            peak_w       = (opac_dropped <= 0) ? PEAK_W'(level_s) : peak_dropped;
          end
          default: begin
            peak_w = st.peak;
          end
        endcase
      end
      // spectrum rules: keep the peak between the level and full scale
      if (!cfg.meter_variant) begin
        if (32'(peak_w) < level_s) begin
          peak_w = PEAK_W'(level_s);
        end else if (peak_w > PEAK_W'(Q_ONE)) begin
          peak_w = PEAK_W'(Q_ONE);
        end
      end
      st_next.peak = peak_w;
    end
  end

endmodule
`default_nettype wire

/* design/peak_hold_fall_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak hold / fall tracker
// Per-band held peak, hold counter, fall rate and opacity, updated once per
// incoming band level with six selectable fall modes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        band_index, band_level, fall_step
//  m_axis    out        tvalid / tready        held_peak, peak_opacity
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle unless the output stalls; results pass the input stage
//  and the result register. Band state sits in one RAM; the read issues at
//  input transfer, then update and write-back, with the last write forwarded.
//  Reset clears all band state at once through per-band valid bits.
//  A stalled output holds the update stage; input is taken while it has room.
// ----------------------------------------------------------------------------
module peak_hold_fall_tracker_unit import phft_pkg::*; #(
  parameter int BAND_COUNT = BAND_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // band_index [7:0], band_level [24:8], fall_step [41:25], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // held_peak [18:0], peak_opacity [37:19], zero pad
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int SW = $bits(band_state_t);

  cfg_t cfg;

  logic [BAND_W-1:0]  in_band;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               accept;
  logic               out_free;
  logic               advance;

  logic               s1_valid;
  logic               s1_range;
  logic               s1_known;
  logic [AW-1:0]      s1_addr;
  logic [LEVEL_W-1:0] s1_level;
  logic [LEVEL_W-1:0] s1_fall_step;

  logic [BAND_COUNT-1:0] known;
  logic                  wb_valid;
  logic [AW-1:0]         wb_addr;
  band_state_t           wb_state;

  logic [SW-1:0] ram_rdata;
  band_state_t   st_cur;
  band_state_t   st_next;
  logic          write_en;

  assign in_band  = s_axis_tdata[BAND_W-1:0];
  assign in_addr  = AW'(in_band);
  assign in_range = 32'(in_band) < 32'(BAND_COUNT);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign write_en      = advance && s1_range;
  assign cfg_ready     = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PEAK_MODE:     cfg.peak_mode       <= cfg_data[2:0];
        REG_HOLD_FRAMES:   cfg.hold_frames     <= cfg_data[HFRAMES_W-1:0];
        REG_HOLD_RECIP:    cfg.hold_reciprocal <= cfg_data[RECIP_W-1:0];
        REG_METER_VARIANT: cfg.meter_variant   <= cfg_data[0];
        default:           cfg <= cfg;
      endcase
    end
  end

  phft_ram #(
    .WIDTH (SW),
    .DEPTH (BAND_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (s1_addr),
    .wdata (st_next),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= in_addr;
      s1_range     <= in_range;
      s1_known     <= in_range && known[in_addr];
      s1_level     <= s_axis_tdata[BAND_W +: LEVEL_W];
      s1_fall_step <= s_axis_tdata[BAND_W+LEVEL_W +: LEVEL_W];
    end
  end

  // forward the latest write; an entry never written reads as zero
  always_comb begin
    if (wb_valid && (wb_addr == s1_addr)) begin
      st_cur = wb_state;
    end else if (s1_known) begin
      st_cur = band_state_t'(ram_rdata);
    end else begin
      st_cur = '0;
    end
  end

  phft_update u_update (
    .cfg       (cfg),
    .st        (st_cur),
    .level     (s1_level),
    .fall_step (s1_fall_step),
    .st_next   (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      known    <= '0;
      wb_valid <= 1'b0;
    end else if (write_en) begin
      known[s1_addr] <= 1'b1;
      wb_valid       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      wb_addr  <= s1_addr;
      wb_state <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_range) begin
        m_axis_tdata <= OUT_TDATA_W'({st_next.opac, st_next.peak});
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak hold / fall tracker testbench
// Streams band updates through the tracker under a series of register
// settings, predicts each band's held peak and opacity in a scoreboard
// class and compares every output transfer against it, with random idle
// cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import phft_pkg::*;

  localparam longint FALL_TOP = (longint'(1) << FALL_W) - 1;
  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam logic VARIANT_SPECTRUM = 1'b0;
  localparam logic VARIANT_METER = 1'b1;
  localparam int PHASES = 14;
  localparam int RANDOM_PER_PHASE = 95;

  typedef struct {
    logic signed [PEAK_W-1:0] peak;
    logic signed [PEAK_W-1:0] opac;
  } peak_result_t;

  class band_peak_tracker;
    logic signed [PEAK_W-1:0] peak_mem [BAND_COUNT_DEF];
    logic signed [HOLD_W-1:0] hold_mem [BAND_COUNT_DEF];
    logic [FALL_W-1:0]        fall_mem [BAND_COUNT_DEF];
    logic signed [PEAK_W-1:0] opac_mem [BAND_COUNT_DEF];
    logic [2:0]               mode;
    logic [HFRAMES_W-1:0]     hold_frames;
    logic [RECIP_W-1:0]       hold_recip;
    logic                     variant;
    peak_result_t             pending_peaks [$];
    int                       fail_count;

    function new();
      foreach (peak_mem[i]) begin
        peak_mem[i] = '0;
        hold_mem[i] = '0;
        fall_mem[i] = '0;
        opac_mem[i] = '0;
      end
      mode = '0;
      hold_frames = '0;
      hold_recip = '0;
      variant = 1'b0;
      fail_count = 0;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PEAK_MODE:     mode = data[2:0];
        REG_HOLD_FRAMES:   hold_frames = data[HFRAMES_W-1:0];
        REG_HOLD_RECIP:    hold_recip = data[RECIP_W-1:0];
        REG_METER_VARIANT: variant = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_peaks.size();
    endfunction

    // Advance one band by one update and queue the result it must produce.
    function void take_update(logic [BAND_W-1:0] band, logic [LEVEL_W-1:0] level,
                              logic [LEVEL_W-1:0] step);
      longint v, fs, hf, pk, hd, fr, op, part;
      bit rise;
      peak_result_t res;
      v = level;
      fs = step;
      hf = hold_frames;
      pk = peak_mem[band];
      hd = hold_mem[band];
      fr = fall_mem[band];
      op = opac_mem[band];
      rise = (mode == MODE_RISE) || (mode == MODE_RISE_FADE);
      if (v >= pk) begin
        if (rise) hd = clip(hd + (((v - pk) * hf) >>> FRAC_BITS), HOLD_MIN, HOLD_MAX);
        else hd = hf;
        pk = v;
        fr = 0;
        op = Q_ONE;
      end else begin
        if (hd > 0) begin
          if (rise) begin
            part = hd < Q_ONE ? hd : Q_ONE;
            pk = clip(pk + ((part * longint'(hold_recip)) >>> FRAC_BITS), PEAK_MIN, PEAK_MAX);
          end
          hd = clip(hd - Q_ONE, HOLD_MIN, HOLD_MAX);
          if (rise && hd > hf) hd = hf;
        end else begin
          case (mode)
            MODE_CLASSIC: begin
              if (variant == VARIANT_SPECTRUM) begin
                fr = fr + Q_TENTH;
                if (fr > fs) fr = fs;
              end else begin
                fr = fs;
              end
              pk = clip(pk - fr, PEAK_MIN, PEAK_MAX);
            end
            MODE_GRAVITY: begin
              fr = clip(fr + fs, 0, FALL_TOP);
              pk = clip(pk - fr, PEAK_MIN, PEAK_MAX);
            end
            MODE_FADE: begin
              fr = clip(fr + fs, 0, FALL_TOP);
              op = clip(op - fr, PEAK_MIN, PEAK_MAX);
              if (op <= 0) pk = v;
            end
            MODE_RISE, MODE_RISE_FADE: begin
              fr = (pk < Q_HALF) ? 2 * fs : fs;
              pk = clip(pk - fr, PEAK_MIN, PEAK_MAX);
              if (mode == MODE_RISE_FADE) begin
                op = clip(op - fr, PEAK_MIN, PEAK_MAX);
                if (op <= 0) pk = v;
              end
            end
            default: ;
          endcase
        end
        // spectrum rules keep the peak between the level and full scale
        if (variant == VARIANT_SPECTRUM) begin
          if (pk < v) pk = v;
          else if (pk > Q_ONE) pk = Q_ONE;
        end
      end
      peak_mem[band] = pk[PEAK_W-1:0];
      hold_mem[band] = hd[HOLD_W-1:0];
      fall_mem[band] = fr[FALL_W-1:0];
      opac_mem[band] = op[PEAK_W-1:0];
      res.peak = pk[PEAK_W-1:0];
      res.opac = op[PEAK_W-1:0];
      pending_peaks.insert(pending_peaks.size(), res);
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] data);
      peak_result_t exp_res;
      logic signed [PEAK_W-1:0] got_peak, got_opac;
      got_peak = data[PEAK_W-1:0];
      got_opac = data[2*PEAK_W-1:PEAK_W];
      if (pending_peaks.size() == 0) begin
        $error("result transfer with nothing outstanding: held_peak %0d peak_opacity %0d",
               got_peak, got_opac);
        fail_count++;
        return;
      end
      exp_res = pending_peaks.pop_front();
      if (got_peak !== exp_res.peak) begin
        $error("held_peak mismatch: expected %0d actual %0d", exp_res.peak, got_peak);
        fail_count++;
      end
      if (got_opac !== exp_res.opac) begin
        $error("peak_opacity mismatch: expected %0d actual %0d", exp_res.opac, got_opac);
        fail_count++;
      end
      if (data[OUT_TDATA_W-1:2*PEAK_W] !== '0) begin
        $error("tdata pad mismatch: expected 0 actual %0h", data[OUT_TDATA_W-1:2*PEAK_W]);
        fail_count++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  bit                     no_idle = 1'b0;

  band_peak_tracker tracker = new();

  peak_hold_fall_tracker_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Output side: check each transfer, then pick next cycle's ready.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata);
    m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_settings(logic [2:0] mode, logic [HFRAMES_W-1:0] frames,
                               logic [RECIP_W-1:0] recip, logic variant);
    write_reg(REG_PEAK_MODE, CFG_DATA_W'(mode));
    write_reg(REG_HOLD_FRAMES, CFG_DATA_W'(frames));
    write_reg(REG_HOLD_RECIP, CFG_DATA_W'(recip));
    write_reg(REG_METER_VARIANT, CFG_DATA_W'(variant));
    cfg_valid <= 1'b0;
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_band_update(logic [BAND_W-1:0] band, logic [LEVEL_W-1:0] level,
                                  logic [LEVEL_W-1:0] step);
    while (!no_idle && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - BAND_W - 2*LEVEL_W){1'b0}}, step, level, band};
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_update(band, level, step);
  endtask

  initial begin
    int ph, n, span;
    logic [BAND_W-1:0] base, band;
    logic [LEVEL_W-1:0] level, step;
    logic [2:0] rnd_mode;
    logic [HFRAMES_W-1:0] rnd_frames;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) drain_results();
      no_idle = (ph == 9);
      case (ph)
        0: load_settings(MODE_CLASSIC, HFRAMES_W'(2 * Q_ONE), RECIP_W'(Q_HALF),
                         VARIANT_SPECTRUM);
        1: load_settings(MODE_GRAVITY, '0, '0, VARIANT_METER);
        2: load_settings(MODE_FADE, HFRAMES_W'(Q_ONE + Q_HALF), RECIP_W'(43690),
                         VARIANT_SPECTRUM);
        3: load_settings(MODE_RISE, HFRAMES_W'(3 * Q_ONE), RECIP_W'(21845),
                         VARIANT_SPECTRUM);
        4: load_settings(MODE_RISE_FADE, '1, '1, VARIANT_METER);
        5: load_settings(MODE_NONE, HFRAMES_W'(2 * Q_ONE), RECIP_W'(Q_ONE),
                         VARIANT_SPECTRUM);
        6: load_settings(MODE_SPARE, HFRAMES_W'(1), RECIP_W'(1), VARIANT_METER);
        7: load_settings(MODE_CLASSIC, '0, '0, VARIANT_METER);
        default: begin
          rnd_mode = 3'($urandom_range(7));
          rnd_frames = ($urandom_range(9) == 0) ? HFRAMES_W'($urandom)
                                                : HFRAMES_W'($urandom_range(8 * Q_ONE));
          load_settings(rnd_mode, rnd_frames, RECIP_W'($urandom_range(131071)),
                        1'($urandom_range(1)));
        end
      endcase

      // capture at full scale, then let the band fall with the largest step
      if (ph < 7) begin
        send_band_update(BAND_W'(ph), LEVEL_W'(Q_ONE), LEVEL_W'(Q_ONE));
        send_band_update(BAND_W'(ph), '0, '1);
        send_band_update(BAND_W'(ph), '0, '1);
      end
      if (ph == 0) begin
        send_band_update('1, '1, '0);
        send_band_update('1, '0, '1);
      end

      base = BAND_W'($urandom_range(255));
      case ($urandom_range(3))
        0: span = 1;
        1: span = 4;
        2: span = 16;
        default: span = 256;
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 3 && n == RANDOM_PER_PHASE / 2) drain_results();
        if ($urandom_range(99) < 85) band = BAND_W'(base + $urandom_range(span - 1));
        else band = BAND_W'($urandom_range(255));
        // mostly low levels so held peaks age and fall; some recaptures
        case ($urandom_range(19))
          0, 1, 2: level = LEVEL_W'($urandom_range(131071));
          3: level = '0;
          4: level = LEVEL_W'(Q_ONE - 1);
          5: level = LEVEL_W'(Q_ONE);
          6: level = '1;
          default: level = LEVEL_W'($urandom_range(8192));
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: step = LEVEL_W'($urandom_range(4096));
          4, 5, 6, 7: step = LEVEL_W'($urandom_range(131071));
          8: step = ($urandom_range(1) == 0) ? LEVEL_W'(0) : LEVEL_W'(Q_ONE);
          default: step = '1;
        endcase
        send_band_update(band, level, step);
      end
    end

    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
